@@ hw/rtl/slvd_pkg.sv @@
// Package for the strap length, velocity and direction block.
// Holds widths, defaults, controller state and command/status types.
// No dependencies.
package slvd_pkg;

  localparam int unsigned COORD_WIDTH_DEF    = 24;
  localparam int unsigned UNIT_FRAC_BITS_DEF = 30;

  localparam int unsigned LEN_W   = 25;
  localparam int unsigned STEP_W  = 25;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned UNIT_W  = 32;
  localparam int unsigned PROD_W  = 2 * LEN_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned RAD_W   = ACC_W + 10;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned SREM_W  = ROOT_W + 2;
  localparam int unsigned DREM_W  = ROOT_W + 1;
  localparam int unsigned DNUM_W  = LEN_W + 24;
  localparam int unsigned CNT_W   = 6;

  localparam int unsigned SQRT_ITERS = ROOT_W;
  localparam int unsigned RATE_ITERS = DNUM_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_RATE_INIT,
    ST_RATE,
    ST_RATE_LATCH,
    ST_UNIT_INIT,
    ST_UNIT,
    ST_UNIT_LATCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       sq;
    logic [1:0] sel;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_rate_init;
    logic       div_unit_init;
    logic       div_step;
    logic       rate_latch;
    logic       unit_latch;
    logic [1:0] comp;
    logic       emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic big;
  } dp_status_t;

endpackage

@@ hw/rtl/slvd_datapath.sv @@
// Datapath: difference vector, squares, bit-serial square root and a shared
// restoring divider for the rate and the unit components. Uses slvd_pkg.
module slvd_datapath import slvd_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int unsigned UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctrl_cmd_t                     cmd_i,
  output dp_status_t                    status_o,
  input  logic                          cfg_we_i,
  input  logic [STEP_W-1:0]             cfg_step_size_i,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] insert_x_i,
  input  logic signed [COORD_WIDTH-1:0] insert_y_i,
  input  logic signed [COORD_WIDTH-1:0] insert_z_i,
  output logic [LEN_W-1:0]              span_length_o,
  output logic signed [RATE_W-1:0]      length_rate_o,
  output logic signed [UNIT_W-1:0]      unit_x_o,
  output logic signed [UNIT_W-1:0]      unit_y_o,
  output logic signed [UNIT_W-1:0]      unit_z_o,
  output logic                          degenerate_o
);

  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned MAGW = (DW > LEN_W) ? DW : LEN_W;
  localparam int unsigned UQW  = UNIT_FRAC_BITS + 1;

  logic signed [DW-1:0]     diff [3];
  logic [DW-1:0]            dmag [3];
  logic [MAGW-1:0]          mag_q [3];
  logic [2:0]               neg_q;
  logic                     shifted_q;
  logic [LEN_W-1:0]         mag25 [3];
  logic [PROD_W-1:0]        prod_q;
  logic [ACC_W-1:0]         acc_q;
  logic [RAD_W-1:0]         rad_q;
  logic [SREM_W-1:0]        srem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [DREM_W-1:0]        drem_q;
  logic [DNUM_W-1:0]        dnum_q;
  logic [ROOT_W-1:0]        div_q;
  logic [STEP_W-1:0]        step_q;
  logic [LEN_W-1:0]         prev_q;
  logic                     have_prev_q;
  logic                     dneg_q;
  logic signed [RATE_W-1:0] rate_q;
  logic signed [UNIT_W-1:0] unit_q [3];
  logic [LEN_W-1:0]         span_o_q;
  logic signed [RATE_W-1:0] rate_o_q;
  logic signed [UNIT_W-1:0] unit_o_q [3];
  logic                     degen_o_q;

  logic [ROOT_W-6:0]          len_w;
  logic [LEN_W-1:0]           cur;
  logic signed [LEN_W:0]      ldiff;
  logic [LEN_W-1:0]           lam;
  logic [SREM_W+1:0]          st;
  logic [SREM_W+1:0]          strial;
  logic [DREM_W:0]            dt;
  logic [UQW-1:0]             uq;
  logic [UNIT_W-1:0]          umag;
  logic                       zero_vec;

  assign diff[0] = $signed({insert_x_i[COORD_WIDTH-1], insert_x_i})
                 - $signed({origin_x_i[COORD_WIDTH-1], origin_x_i});
  assign diff[1] = $signed({insert_y_i[COORD_WIDTH-1], insert_y_i})
                 - $signed({origin_y_i[COORD_WIDTH-1], origin_y_i});
  assign diff[2] = $signed({insert_z_i[COORD_WIDTH-1], insert_z_i})
                 - $signed({origin_z_i[COORD_WIDTH-1], origin_z_i});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i]  = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
      mag25[i] = mag_q[i][LEN_W-1:0];
    end
  end

  assign status_o.big = ((mag_q[0] >> LEN_W) != '0) || ((mag_q[1] >> LEN_W) != '0)
                     || ((mag_q[2] >> LEN_W) != '0);

  assign zero_vec = (acc_q == '0);
  assign len_w    = root_q[ROOT_W-1:5];
  always_comb begin
    if (shifted_q || (len_w[ROOT_W-6:LEN_W] != '0)) begin
      cur = '1;
    end else begin
      cur = len_w[LEN_W-1:0];
    end
  end
  assign ldiff = $signed({1'b0, cur}) - $signed({1'b0, prev_q});
  assign lam   = ldiff[LEN_W] ? LEN_W'(-ldiff) : LEN_W'(ldiff);

  assign st     = {srem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign strial = (SREM_W+2)'({root_q, 2'b01});
  assign dt     = {drem_q, dnum_q[DNUM_W-1]};
  assign uq     = dnum_q[UQW-1:0];
  always_comb begin
    if (uq[UQW-1]) begin
      umag = UNIT_W'(1) << UNIT_FRAC_BITS;
    end else begin
      umag = UNIT_W'(uq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) mag_q[i] <= MAGW'(dmag[i]);
      neg_q     <= {diff[2][DW-1], diff[1][DW-1], diff[0][DW-1]};
      shifted_q <= 1'b0;
      prod_q    <= '0;
      acc_q     <= '0;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      shifted_q <= 1'b1;
    end else if (cmd_i.sq) begin
      if (cmd_i.sel == 2'd3) begin
        prod_q <= '0;
      end else begin
        prod_q <= mag25[cmd_i.sel] * mag25[cmd_i.sel];
      end
      acc_q <= acc_q + ACC_W'(prod_q);
    end

    if (cmd_i.sqrt_init) begin
      rad_q  <= {acc_q, 10'd0};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (st >= strial) begin
        srem_q <= SREM_W'(st - strial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= SREM_W'(st);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd_i.div_rate_init) begin
      drem_q <= '0;
      dnum_q <= {lam, 24'd0};
      div_q  <= ROOT_W'(step_q);
      dneg_q <= ldiff[LEN_W];
    end else if (cmd_i.div_unit_init) begin
      drem_q <= DREM_W'({mag25[cmd_i.comp], 4'd0});
      dnum_q <= '0;
      div_q  <= root_q;
    end else if (cmd_i.div_step) begin
      if (dt >= (DREM_W+1)'(div_q)) begin
        drem_q <= DREM_W'(dt - (DREM_W+1)'(div_q));
        dnum_q <= {dnum_q[DNUM_W-2:0], 1'b1};
      end else begin
        drem_q <= DREM_W'(dt);
        dnum_q <= {dnum_q[DNUM_W-2:0], 1'b0};
      end
    end

    if (cmd_i.rate_latch) begin
      if (!have_prev_q || (step_q == '0)) begin
        rate_q <= '0;
      end else if (dneg_q) begin
        rate_q <= (dnum_q > DNUM_W'(64'h8000_0000)) ? RATE_W'(64'h8000_0000)
                                                     : RATE_W'(-dnum_q);
      end else begin
        rate_q <= (dnum_q > DNUM_W'(64'h7FFF_FFFF)) ? RATE_W'(64'h7FFF_FFFF)
                                                     : RATE_W'(dnum_q);
      end
    end

    if (cmd_i.unit_latch) begin
      if (zero_vec) begin
        unit_q[cmd_i.comp] <= '0;
      end else if (neg_q[cmd_i.comp]) begin
        unit_q[cmd_i.comp] <= -umag;
      end else begin
        unit_q[cmd_i.comp] <= umag;
      end
    end

    if (cmd_i.emit) begin
      span_o_q  <= cur;
      rate_o_q  <= rate_q;
      unit_o_q  <= unit_q;
      degen_o_q <= zero_vec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cfg_we_i) step_q <= cfg_step_size_i;
      if (cmd_i.emit) begin
        prev_q      <= cur;
        have_prev_q <= 1'b1;
      end
    end
  end

  assign span_length_o = span_o_q;
  assign length_rate_o = rate_o_q;
  assign unit_x_o      = unit_o_q[0];
  assign unit_y_o      = unit_o_q[1];
  assign unit_z_o      = unit_o_q[2];
  assign degenerate_o  = degen_o_q;

endmodule

@@ hw/rtl/slvd_ctrl.sv @@
// Controller: sequences normalize, squares, root, rate and unit divisions,
// and owns the input and output handshakes. Uses slvd_pkg.
module slvd_ctrl import slvd_pkg::*; #(
  parameter int unsigned UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_ITERS - 1);
  localparam logic [CNT_W-1:0] RATE_LAST = CNT_W'(RATE_ITERS - 1);
  localparam logic [CNT_W-1:0] UNIT_LAST = CNT_W'(UNIT_FRAC_BITS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       comp_q, comp_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !(out_valid_q && out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_NORM;
      ST_NORM: begin
        if (!status_i.big) begin
          state_d = ST_SQ;
          cnt_d   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_q == CNT_W'(3)) state_d = ST_SQRT_INIT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_SQRT_INIT: begin
        state_d = ST_SQRT;
        cnt_d   = '0;
      end
      ST_SQRT: begin
        if (cnt_q == SQRT_LAST) state_d = ST_RATE_INIT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_RATE_INIT: begin
        state_d = ST_RATE;
        cnt_d   = '0;
      end
      ST_RATE: begin
        if (cnt_q == RATE_LAST) state_d = ST_RATE_LATCH;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_RATE_LATCH: begin
        state_d = ST_UNIT_INIT;
        comp_d  = '0;
      end
      ST_UNIT_INIT: begin
        state_d = ST_UNIT;
        cnt_d   = '0;
      end
      ST_UNIT: begin
        if (cnt_q == UNIT_LAST) state_d = ST_UNIT_LATCH;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_UNIT_LATCH: begin
        if (comp_q == 2'd2) begin
          state_d = ST_EMIT;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = ST_UNIT_INIT;
        end
      end
      ST_EMIT:       if (slot_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.sel   = cnt_q[1:0];
    cmd_o.comp  = comp_q;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_NORM:       cmd_o.shift = status_i.big;
      ST_SQ:         cmd_o.sq = 1'b1;
      ST_SQRT_INIT:  cmd_o.sqrt_init = 1'b1;
      ST_SQRT:       cmd_o.sqrt_step = 1'b1;
      ST_RATE_INIT:  cmd_o.div_rate_init = 1'b1;
      ST_RATE:       cmd_o.div_step = 1'b1;
      ST_RATE_LATCH: cmd_o.rate_latch = 1'b1;
      ST_UNIT_INIT:  cmd_o.div_unit_init = 1'b1;
      ST_UNIT:       cmd_o.div_step = 1'b1;
      ST_UNIT_LATCH: cmd_o.unit_latch = 1'b1;
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/strap_length_velocity_direction.sv @@
// Top level: strap span length, length rate and unit direction.
// Instantiates slvd_ctrl and slvd_datapath; uses slvd_pkg.
//
// Input channel (in_valid_i / in_stall_o) takes one origin and one insertion
// point per item. Output channel (out_valid_o / out_stall_i) returns one
// result item per input item, in order. The step size register is written
// through cfg_valid_i / cfg_ready_o / cfg_step_size_i; ready is always high.
// While any component difference reaches 2^25 (only when COORD_WIDTH > 24),
// all three are halved before the squares. The work is done by the
// bit-serial square root (31 steps), the rate division (49 steps) and three
// unit divisions on the one shared divider.
// One item is in work at a time; the next is taken as soon as the previous
// one has moved into the output register, even if that result is stalled.
// A stalled result holds; a finished item waits for the output register.
// Reset clears the step size, the previous length and the handshakes; the
// first item after reset reports a rate of zero.
module strap_length_velocity_direction import slvd_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int unsigned UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [STEP_W-1:0]             cfg_step_size_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] insert_x_i,
  input  logic signed [COORD_WIDTH-1:0] insert_y_i,
  input  logic signed [COORD_WIDTH-1:0] insert_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LEN_W-1:0]              span_length_o,
  output logic signed [RATE_W-1:0]      length_rate_o,
  output logic signed [UNIT_W-1:0]      unit_x_o,
  output logic signed [UNIT_W-1:0]      unit_y_o,
  output logic signed [UNIT_W-1:0]      unit_z_o,
  output logic                          degenerate_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  slvd_ctrl #(
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slvd_datapath #(
    .COORD_WIDTH   (COORD_WIDTH),
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_step_size_i(cfg_step_size_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .origin_z_i     (origin_z_i),
    .insert_x_i     (insert_x_i),
    .insert_y_i     (insert_y_i),
    .insert_z_i     (insert_z_i),
    .span_length_o  (span_length_o),
    .length_rate_o  (length_rate_o),
    .unit_x_o       (unit_x_o),
    .unit_y_o       (unit_y_o),
    .unit_z_o       (unit_z_o),
    .degenerate_o   (degenerate_o)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for strap_length_velocity_direction.
// Items enter from a queue and the bench predicts length, rate and direction;
// needs only slvd_pkg and the block's RTL.
module testbench import slvd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int UFB = UNIT_FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 200;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, ix, iy, iz;
  } strap_item_t;

  typedef struct {
    logic [LEN_W-1:0] span;
    logic [RATE_W-1:0] rate;
    logic [UNIT_W-1:0] ux, uy, uz;
    logic degen;
  } strap_result_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [STEP_W-1:0] cfg_step_size_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [CW-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [CW-1:0] insert_x_i = '0, insert_y_i = '0, insert_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [LEN_W-1:0] span_length_o;
  logic signed [RATE_W-1:0] length_rate_o;
  logic signed [UNIT_W-1:0] unit_x_o, unit_y_o, unit_z_o;
  logic degenerate_o;

  strap_length_velocity_direction u_top (.*);

  strap_item_t coord_q[$];
  strap_result_t want_q[$];
  int errors = 0;
  longint cycles = 0;

  // predictor state
  logic [STEP_W-1:0] step_reg = '0;
  logic [LEN_W-1:0] prev_len = '0;
  bit have_prev = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic strap_result_t strap_geometry(strap_item_t it);
    strap_result_t res;
    longint d[3];
    longint unsigned m[3], sum, root, u, q, am, lim;
    longint diff, rate;
    logic [LEN_W-1:0] cur;
    d[0] = longint'(it.ix) - longint'(it.ox);
    d[1] = longint'(it.iy) - longint'(it.oy);
    d[2] = longint'(it.iz) - longint'(it.oz);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? -d[i] : d[i];
      sum += m[i] * m[i];
    end
    root = int_sqrt(sum);
    cur = root > 33554431 ? 25'h1FFFFFF : root[LEN_W-1:0];
    rate = 0;
    if (have_prev && step_reg != 0) begin
      diff = longint'(cur) - longint'(prev_len);
      am = diff < 0 ? -diff : diff;
      q = (am << 24) / step_reg;
      if (diff < 0) rate = q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
      else rate = q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
    end
    res.span = cur;
    res.rate = rate[31:0];
    res.ux = '0;
    res.uy = '0;
    res.uz = '0;
    res.degen = (sum == 0);
    if (sum != 0) begin
      root = int_sqrt(sum << 10);
      lim = 64'd1 << UFB;
      for (int i = 0; i < 3; i++) begin
        u = (m[i] << (UFB + 5)) / root;
        if (u > lim) u = lim;
        if (d[i] < 0) u = -u;
        if (i == 0) res.ux = u[31:0];
        else if (i == 1) res.uy = u[31:0];
        else res.uz = u[31:0];
      end
    end
    prev_len = cur;
    have_prev = 1;
    return res;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  task automatic add_coord(strap_item_t it);
    coord_q = {coord_q, it};
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic strap_item_t rand_item();
    strap_item_t it;
    int span;
    it.ox = rand_coord(); it.oy = rand_coord(); it.oz = rand_coord();
    case ($urandom_range(0, 9))
      0: begin it.ix = it.ox; it.iy = it.oy; it.iz = it.oz; end
      1, 2, 3: begin
        span = 1 << $urandom_range(0, 20);
        it.ix = it.ox + CW'($urandom_range(0, 2*span) - span);
        it.iy = it.oy + CW'($urandom_range(0, 2*span) - span);
        it.iz = it.oz + CW'($urandom_range(0, 2*span) - span);
      end
      default: begin it.ix = rand_coord(); it.iy = rand_coord(); it.iz = rand_coord(); end
    endcase
    return it;
  endfunction

  function automatic strap_item_t mk(int ox, int oy, int oz, int ix, int iy, int iz);
    strap_item_t it;
    it.ox = CW'(ox); it.oy = CW'(oy); it.oz = CW'(oz);
    it.ix = CW'(ix); it.iy = CW'(iy); it.iz = CW'(iz);
    return it;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        strap_item_t acc;
        acc.ox = origin_x_i; acc.oy = origin_y_i; acc.oz = origin_z_i;
        acc.ix = insert_x_i; acc.iy = insert_y_i; acc.iz = insert_z_i;
        want_q = {want_q, strap_geometry(acc)};
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 0;
        end else if (coord_q.size() != 0) begin
          strap_item_t nx;
          nx = coord_q.pop_front();
          origin_x_i <= nx.ox; origin_y_i <= nx.oy; origin_z_i <= nx.oz;
          insert_x_i <= nx.ix; insert_y_i <= nx.iy; insert_z_i <= nx.iz;
          in_valid_i <= 1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 400);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 0;
        end
      end
    end
  end

  // receiver: stall pattern switches mode every so often
  int stall_mode = 0, mode_left = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(50, 3000);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 0;
      1: out_stall_i <= $urandom_range(0, 1);
      2: out_stall_i <= $urandom_range(0, 7) != 0;
      default: out_stall_i <= (cycles % 300) < 250;
    endcase
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        strap_result_t w;
        w = want_q.pop_front();
        if (span_length_o !== w.span) report("span_length", span_length_o, w.span);
        if (length_rate_o !== w.rate) report("length_rate", length_rate_o, w.rate);
        if (unit_x_o !== w.ux) report("unit_x", unit_x_o, w.ux);
        if (unit_y_o !== w.uy) report("unit_y", unit_y_o, w.uy);
        if (unit_z_o !== w.uz) report("unit_z", unit_z_o, w.uz);
        if (degenerate_o !== w.degen) report("degenerate", degenerate_o, w.degen);
      end
    end
  end

  task automatic drain();
    while (coord_q.size() != 0 || in_valid_i || want_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_step(logic [STEP_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_step_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    step_reg = v;
    cfg_valid_i <= 0;
  endtask

  localparam int MINC = -(1 << (CW-1));
  localparam int MAXC = (1 << (CW-1)) - 1;

  initial begin
    logic [STEP_W-1:0] steps[7];
    steps = '{25'd0, 25'd1, 25'd16777216, 25'h1FFFFFF, 25'd0, 25'd0, 25'd0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    // first step after reset, coincident, extremes, single axes
    add_coord(mk(0, 0, 0, 65536, 0, 0));
    add_coord(mk(0, 0, 0, 0, 0, 0));
    add_coord(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC));
    add_coord(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC));
    add_coord(mk(MAXC, MINC, MAXC, MAXC, MINC, MAXC));
    add_coord(mk(MINC, 0, 0, MAXC, 0, 0));
    add_coord(mk(0, MAXC, 0, 0, MINC, 0));
    add_coord(mk(0, 0, 0, 0, 0, 1));
    add_coord(mk(5, -7, 3, 4, -6, 2));
    add_coord(mk(100, 200, 300, 100, 200, 300));
    drain();
    for (int p = 0; p < 7; p++) begin
      if (p >= 4) steps[p] = p == 4 ? STEP_W'($urandom_range(1, 4096))
                                    : STEP_W'($urandom_range(1, 33554431));
      write_step(steps[p]);
      for (int n = 0; n < 236; n++) add_coord(rand_item());
      drain();
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
